FILE: sv/blpw_pkg.sv
// Package with the constants, register indexes and colour formatting of the line writer.
package blpw_pkg;

  localparam int FW_W      = 13;
  localparam int ADDR_W    = 32;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BASE  = 2'd2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  localparam logic FMT_ARGB8888 = 1'b0;
  localparam logic FMT_RGB565   = 1'b1;

  localparam logic PEN_WHITE = 1'b0;
  localparam logic PEN_BLACK = 1'b1;

  localparam logic [DATA_W-1:0] ARGB_WHITE   = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] ARGB_BLACK   = 32'hFF00_0000;
  localparam logic [DATA_W-1:0] RGB565_WHITE = 32'h0000_FFFF;
  localparam logic [DATA_W-1:0] RGB565_BLACK = 32'h0000_0000;

  function automatic logic [DATA_W-1:0] format_color(input logic c, input logic fmt);
    logic [DATA_W-1:0] res;
    if (fmt == FMT_ARGB8888) begin
      res = (c == PEN_BLACK) ? ARGB_BLACK : ARGB_WHITE;
    end else begin
      res = (c == PEN_BLACK) ? RGB565_BLACK : RGB565_WHITE;
    end
    return res;
  endfunction

endpackage

FILE: sv/bresenham_line_pixel_writer.sv
// Bresenham line raster engine that turns step items into framebuffer writes.
//
// A load item (mode 0) sets up a line from its two endpoints and colour and gives no write;
// each step item (mode 1) gives one framebuffer write for the current pixel and advances the
// line by one Bresenham step, with last set on the final pixel. Step items with no line in
// progress give nothing. One item is taken every clock unless item_stall is high: the
// Bresenham step is done in the cycle an item is accepted, and the write is presented on
// the outputs after passing the row-stride multiplier stage register and then the output
// register, which captures the result of the address adder.
// Configuration registers are to be written only while no write is pending.
module bresenham_line_pixel_writer
  import blpw_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  mode,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic                  color,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [ADDR_W-1:0]     address,
  output logic [DATA_W-1:0]     pixel_data,
  output logic                  half_word,
  output logic                  last
);

  localparam int ERR_W  = COORD_BITS + 1;
  localparam int SUM_W  = COORD_BITS + 2;
  localparam int PROD_W = COORD_BITS + FW_W;
  localparam int IDX_W  = PROD_W + 1;

  logic [FW_W-1:0]   frame_width;
  logic              pixel_format;
  logic [ADDR_W-1:0] buffer_base;

  logic                  line_active;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [ERR_W-1:0]      error_acc;
  logic [COORD_BITS-1:0] major_delta;
  logic [COORD_BITS-1:0] minor_delta;
  logic                  x_major_axis;
  logic                  x_negative;
  logic                  y_negative;
  logic [ERR_W-1:0]      pixels_left;
  logic                  line_color;

  logic                  s1_valid;
  logic [PROD_W-1:0]     s1_prod;
  logic [COORD_BITS-1:0] s1_x;
  logic                  s1_color;
  logic                  s1_last;

  logic accept;
  logic emit;
  logic out_adv;
  logic s1_adv;

  logic                  ld_x_neg;
  logic                  ld_y_neg;
  logic [COORD_BITS-1:0] ld_dx;
  logic [COORD_BITS-1:0] ld_dy;
  logic                  ld_x_major;
  logic [COORD_BITS-1:0] ld_major;
  logic [COORD_BITS-1:0] ld_minor;

  logic [SUM_W-1:0]      err_sum;
  logic                  err_ge;
  logic [ERR_W-1:0]      error_acc_next;
  logic [COORD_BITS-1:0] cur_x_next;
  logic [COORD_BITS-1:0] cur_y_next;
  logic [COORD_BITS-1:0] x_stepped;
  logic [COORD_BITS-1:0] y_stepped;
  logic [ERR_W-1:0]      pixels_left_next;

  logic [IDX_W-1:0]  pix_index;
  logic [ADDR_W-1:0] index_wide;
  logic [ADDR_W-1:0] byte_offset;

  assign out_adv    = !result_valid || !result_stall;
  assign s1_adv     = !s1_valid || out_adv;
  assign item_stall = !s1_adv;
  assign accept     = item_valid && !item_stall;
  assign emit       = accept && (mode == MODE_STEP) && line_active;

  always_comb begin
    ld_x_neg   = end_x < start_x;
    ld_y_neg   = end_y < start_y;
    ld_dx      = ld_x_neg ? (start_x - end_x) : (end_x - start_x);
    ld_dy      = ld_y_neg ? (start_y - end_y) : (end_y - start_y);
    ld_x_major = ld_dx >= ld_dy;
    ld_major   = ld_x_major ? ld_dx : ld_dy;
    ld_minor   = ld_x_major ? ld_dy : ld_dx;
  end

  always_comb begin
    err_sum          = {1'b0, error_acc} + {2'b00, minor_delta};
    err_ge           = err_sum >= {2'b00, major_delta};
    error_acc_next   = err_ge ? ERR_W'(err_sum - {2'b00, major_delta}) : ERR_W'(err_sum);
    x_stepped        = x_negative ? (cur_x - 1'b1) : (cur_x + 1'b1);
    y_stepped        = y_negative ? (cur_y - 1'b1) : (cur_y + 1'b1);
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    if (x_major_axis) begin
      cur_x_next = x_stepped;
      if (err_ge) begin
        cur_y_next = y_stepped;
      end
    end else begin
      cur_y_next = y_stepped;
      if (err_ge) begin
        cur_x_next = x_stepped;
      end
    end
    pixels_left_next = pixels_left - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= '0;
      pixel_format <= FMT_ARGB8888;
      buffer_base  <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[0];
        REG_BUFFER_BASE:  buffer_base  <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active  <= 1'b0;
      cur_x        <= '0;
      cur_y        <= '0;
      error_acc    <= '0;
      major_delta  <= '0;
      minor_delta  <= '0;
      x_major_axis <= 1'b0;
      x_negative   <= 1'b0;
      y_negative   <= 1'b0;
      pixels_left  <= '0;
      line_color   <= PEN_WHITE;
    end else if (accept && (mode == MODE_LOAD)) begin
      line_active  <= 1'b1;
      cur_x        <= start_x;
      cur_y        <= start_y;
      error_acc    <= {1'b0, ld_major >> 1};
      major_delta  <= ld_major;
      minor_delta  <= ld_minor;
      x_major_axis <= ld_x_major;
      x_negative   <= ld_x_neg;
      y_negative   <= ld_y_neg;
      pixels_left  <= {1'b0, ld_major} + 1'b1;
      line_color   <= color;
    end else if (emit) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      error_acc   <= error_acc_next;
      pixels_left <= pixels_left_next;
      if (pixels_left_next == '0) begin
        line_active <= 1'b0;
      end
    end
  end

  // First stage: the row offset product of the pixel being emitted.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      s1_prod  <= PROD_W'(cur_y) * PROD_W'(frame_width);
      s1_x     <= cur_x;
      s1_color <= line_color;
      s1_last  <= pixels_left == ERR_W'(1);
    end
  end

  always_comb begin
    pix_index   = {1'b0, s1_prod} + IDX_W'(s1_x);
    index_wide  = ADDR_W'(pix_index);
    byte_offset = (pixel_format == FMT_RGB565) ? {index_wide[ADDR_W-2:0], 1'b0}
                                               : {index_wide[ADDR_W-3:0], 2'b00};
  end

  // Output register: address, formatted colour and write size.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_adv) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      address    <= buffer_base + byte_offset;
      pixel_data <= format_color(s1_color, pixel_format);
      half_word  <= pixel_format == FMT_RGB565;
      last       <= s1_last;
    end
  end

endmodule
